FILE: hdl/mfde_pkg.sv
// Shared types and constants of the mono framebuffer draw engine.
package mfde_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 128;
    localparam int CFG_W_BITS     = 9;
    localparam int CFG_H_BITS     = 8;

    typedef enum logic [2:0] {
        OP_FILL  = 3'd0,
        OP_SET   = 3'd1,
        OP_GET   = 3'd2,
        OP_LINE  = 3'd3,
        OP_FRECT = 3'd4,
        OP_IRECT = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1
    } reg_index_t;

    typedef enum logic [2:0] {
        K_NOP   = 3'd0,
        K_FILL  = 3'd1,
        K_PIXEL = 3'd2,
        K_GET   = 3'd3,
        K_LINE  = 3'd4,
        K_RECT  = 3'd5
    } kind_t;

    // Decoded request handed from the front to the back.
    typedef struct packed {
        kind_t              kind;
        logic               ink;
        logic               invert;
        logic signed [15:0] xa;
        logic signed [15:0] ya;
        logic signed [15:0] xb;
        logic signed [15:0] yb;
    } cmd_t;

endpackage

FILE: hdl/mfde_ram.sv
// Generic single-port RAM with registered read.
module mfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: hdl/mfde_front.sv
// Front end: accepts requests, clips rectangles, queues decoded commands.
module mfde_front import mfde_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int EW         = $clog2(MAX_WIDTH + 1),
    parameter int HW         = $clog2(MAX_HEIGHT + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         opcode,
    input  logic signed [15:0] x_start,
    input  logic signed [15:0] y_start,
    input  logic signed [15:0] x_other,
    input  logic signed [15:0] y_other,
    input  logic               ink,
    input  logic [EW-1:0]      eff_w,
    input  logic [HW-1:0]      eff_h,
    input  logic               clearing,
    output logic               cmd_valid,
    output cmd_t               cmd,
    input  logic               cmd_pop
);

    logic signed [17:0] xs, ys, xe, ye, x0, y0, xc, yc, wl, hl;
    logic               rect_empty;
    cmd_t               dec;
    cmd_t               q [2];
    logic               wp_reg, rp_reg;
    logic [1:0]         cnt_reg;
    logic               accept;

    always_comb
    begin
        xs = 18'(x_start);
        ys = 18'(y_start);
        xe = xs + 18'(x_other);
        ye = ys + 18'(y_other);
        wl = signed'(18'(eff_w));
        hl = signed'(18'(eff_h));
        x0 = (xs < 0) ? '0 : xs;
        y0 = (ys < 0) ? '0 : ys;
        xc = (xe > wl) ? wl : xe;
        yc = (ye > hl) ? hl : ye;
        rect_empty = (x_other <= 0) || (y_other <= 0) || (x0 >= xc) || (y0 >= yc);

        dec.kind   = K_NOP;
        dec.ink    = ink;
        dec.invert = 1'b0;
        dec.xa     = x_start;
        dec.ya     = y_start;
        dec.xb     = x_start;
        dec.yb     = y_start;
        case (opcode)
            OP_FILL: dec.kind = K_FILL;
            OP_SET:  dec.kind = K_PIXEL;
            OP_GET:  dec.kind = K_GET;
            OP_LINE:
            begin
                dec.kind = K_LINE;
                dec.xb   = x_other;
                dec.yb   = y_other;
            end
            OP_FRECT, OP_IRECT:
            begin
                dec.kind   = rect_empty ? K_NOP : K_RECT;
                dec.invert = (opcode == OP_IRECT);
                dec.xa     = x0[15:0];
                dec.ya     = y0[15:0];
                dec.xb     = 16'(xc - 18'sd1);
                dec.yb     = 16'(yc - 18'sd1);
            end
            default: dec.kind = K_NOP;
        endcase
    end

    assign full      = (cnt_reg == 2'd2) || clearing;
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg <= ~wp_reg;
            end
            if (cmd_pop && cmd_valid)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(accept) - 2'(cmd_pop && cmd_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q[wp_reg] <= dec;
        end
    end

endmodule

FILE: hdl/mfde_back.sv
// Back end: walks pixels of each command through read-modify-write of the store.
module mfde_back import mfde_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int EW         = $clog2(MAX_WIDTH + 1),
    parameter int HW         = $clog2(MAX_HEIGHT + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [EW-1:0] eff_w,
    input  logic [HW-1:0] eff_h,
    output logic          clearing,
    input  logic          cmd_valid,
    input  cmd_t          cmd,
    output logic          cmd_pop,
    output logic          empty,
    input  logic          pop,
    output logic          ink_read
);

    localparam int STRIDE_MAX = (MAX_WIDTH + 7) / 8;
    localparam int DEPTH      = STRIDE_MAX * MAX_HEIGHT;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW         = $clog2(STRIDE_MAX + 1);

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_INIT = 7'b0000100,
        S_PIX  = 7'b0001000,
        S_WR   = 7'b0010000,
        S_FILL = 7'b0100000,
        S_RES  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    kind_t              kind_reg;
    logic               ink_reg, inv_reg;
    logic signed [15:0] x_reg, y_reg, xe_reg, ye_reg, xl_reg;
    logic signed [19:0] dx_reg, dy_reg, err_reg;
    logic               sxn_reg, syn_reg;
    logic [AW-1:0]      addr_reg;
    logic [7:0]         mask_reg;
    logic [AW:0]        cnt_reg, fill_n_reg;
    logic               res_reg;

    logic [SW-1:0]      stride;
    logic               in_bounds, last;
    logic [AW-1:0]      pix_addr;
    logic signed [19:0] e2, err_n, ddx, ddy;
    logic               cx, cy;
    logic signed [15:0] x_n, y_n;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [7:0]         ram_wdata, ram_rdata, new_byte;

    logic               rbuf [2];
    logic               rwp_reg, rrp_reg;
    logic [1:0]         rcnt_reg;
    logic               rpush, rpop;

    mfde_ram #(.WIDTH(8), .DEPTH(DEPTH), .AW(AW)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        stride    = SW'((32'(eff_w) + 32'd7) >> 3);
        in_bounds = (x_reg >= 0) && (18'(x_reg) < signed'(18'(eff_w)))
                 && (y_reg >= 0) && (18'(y_reg) < signed'(18'(eff_h)));
        pix_addr  = AW'(32'(y_reg[15:0]) * 32'(stride) + 32'(x_reg[15:3]));
        last      = (x_reg == xe_reg) && (y_reg == ye_reg);

        ddx = 20'(xe_reg) - 20'(x_reg);
        ddy = 20'(ye_reg) - 20'(y_reg);
        e2  = err_reg <<< 1;
        cx  = (e2 >= dy_reg);
        cy  = (e2 <= dx_reg);
        err_n = err_reg + (cx ? dy_reg : 20'sd0) + (cy ? dx_reg : 20'sd0);

        if (kind_reg == K_LINE)
        begin
            x_n = cx ? (sxn_reg ? x_reg - 16'sd1 : x_reg + 16'sd1) : x_reg;
            y_n = cy ? (syn_reg ? y_reg - 16'sd1 : y_reg + 16'sd1) : y_reg;
        end
        else if (x_reg == xe_reg)
        begin
            x_n = xl_reg;
            y_n = y_reg + 16'sd1;
        end
        else
        begin
            x_n = x_reg + 16'sd1;
            y_n = y_reg;
        end

        if (inv_reg)
        begin
            new_byte = ram_rdata ^ mask_reg;
        end
        else if (ink_reg)
        begin
            new_byte = ram_rdata & ~mask_reg;
        end
        else
        begin
            new_byte = ram_rdata | mask_reg;
        end

        ram_we    = 1'b0;
        ram_addr  = addr_reg;
        ram_wdata = new_byte;
        case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_addr  = cnt_reg[AW-1:0];
                ram_wdata = 8'hFF;
            end
            S_FILL:
            begin
                ram_we    = (cnt_reg < fill_n_reg);
                ram_addr  = cnt_reg[AW-1:0];
                ram_wdata = ink_reg ? 8'h00 : 8'hFF;
            end
            S_PIX:   ram_addr = pix_addr;
            S_WR:    ram_we = (kind_reg != K_GET);
            default: ram_we = 1'b0;
        endcase
    end

    assign clearing = (state_reg == S_CLR);
    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;
    assign rpush    = (state_reg == S_RES) && (rcnt_reg != 2'd2);
    assign rpop     = pop && !empty;
    assign empty    = (rcnt_reg == 2'd0);
    assign ink_read = rbuf[rrp_reg];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (cnt_reg == (AW+1)'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        K_FILL:               state_next = S_FILL;
                        K_LINE:               state_next = S_INIT;
                        K_PIXEL, K_GET, K_RECT: state_next = S_PIX;
                        default:              state_next = S_RES;
                    endcase
                end
            end
            S_INIT: state_next = S_PIX;
            S_PIX:
            begin
                if (in_bounds)
                begin
                    state_next = S_WR;
                end
                else if (last || kind_reg != K_LINE)
                begin
                    state_next = S_RES;
                end
            end
            S_WR:   state_next = last ? S_RES : S_PIX;
            S_FILL:
            begin
                if (cnt_reg >= fill_n_reg)
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                if (rcnt_reg != 2'd2)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            rwp_reg   <= 1'b0;
            rrp_reg   <= 1'b0;
            rcnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_CLR:   cnt_reg <= (state_next == S_IDLE) ? '0 : cnt_reg + 1'b1;
                S_IDLE:  cnt_reg <= '0;
                S_FILL:  cnt_reg <= cnt_reg + 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
            if (rpush)
            begin
                rwp_reg <= ~rwp_reg;
            end
            if (rpop)
            begin
                rrp_reg <= ~rrp_reg;
            end
            rcnt_reg <= rcnt_reg + 2'(rpush) - 2'(rpop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rpush)
        begin
            rbuf[rwp_reg] <= res_reg;
        end
        case (state_reg)
            S_IDLE:
            begin
                kind_reg   <= cmd.kind;
                ink_reg    <= cmd.ink;
                inv_reg    <= cmd.invert;
                x_reg      <= cmd.xa;
                y_reg      <= cmd.ya;
                xl_reg     <= cmd.xa;
                xe_reg     <= cmd.xb;
                ye_reg     <= cmd.yb;
                res_reg    <= 1'b0;
                fill_n_reg <= (AW+1)'(32'(stride) * 32'(eff_h));
            end
            S_INIT:
            begin
                dx_reg  <= (ddx < 0) ? -ddx : ddx;
                dy_reg  <= (ddy < 0) ? ddy : -ddy;
                err_reg <= ((ddx < 0) ? -ddx : ddx) + ((ddy < 0) ? ddy : -ddy);
                sxn_reg <= !(x_reg < xe_reg);
                syn_reg <= !(y_reg < ye_reg);
            end
            S_PIX:
            begin
                addr_reg <= pix_addr;
                mask_reg <= 8'h80 >> x_reg[2:0];
                // step past a clipped point of a line
                if (!in_bounds && !last && kind_reg == K_LINE)
                begin
                    x_reg   <= x_n;
                    y_reg   <= y_n;
                    err_reg <= err_n;
                end
            end
            S_WR:
            begin
                if (kind_reg == K_GET)
                begin
                    res_reg <= ((ram_rdata & mask_reg) == 8'h00);
                end
                if (!last)
                begin
                    x_reg <= x_n;
                    y_reg <= y_n;
                    if (kind_reg == K_LINE)
                    begin
                        err_reg <= err_n;
                    end
                end
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_RES) |-> !ram_we)
        else $error("store written outside a command");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> $past(state_reg) == S_PIX)
        else $error("modify without preceding read");

    a_result_depth: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg <= 2'd2)
        else $error("result queue overflow");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        rpush |=> state_reg == S_IDLE)
        else $error("result pushed without return to idle");

endmodule

FILE: hdl/mono_framebuffer_draw_engine_unit.sv
// Top level of the mono framebuffer draw engine.
// Requests enter through push/full: a request is taken on a rising edge with
// push high and full low. Each request yields exactly one result, read through
// empty/pop: ink_read is valid while empty is low and leaves on pop.
// ink_read is the pixel for get pixel and 0 for every other request.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 width, 1 height) and
// cfg_data; cfg_ready is always high. Write it only while no request is open.
// After reset the store is swept to white, one byte per cycle, over all
// ((MAX_WIDTH+7)/8)*MAX_HEIGHT bytes (4096 at the defaults); full stays high.
// Requests are carried out one at a time by a read-modify-write sequencer
// on the single store port: a drawn or read pixel is read in S_PIX and,
// if drawn, written in S_WR; a clipped point is passed over in S_PIX; fill
// screen writes the visible rows byte by byte; a line is set up in S_INIT.
// A two-entry command queue lets up to two requests wait while one runs.
// A two-entry result queue parts the sequencer from the reader; when the
// reader stalls with it full, the sequencer holds and full rises in turn.
module mono_framebuffer_draw_engine_unit import mfde_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [2:0]            opcode,
    input  logic signed [15:0]    x_start,
    input  logic signed [15:0]    y_start,
    input  logic signed [15:0]    x_other,
    input  logic signed [15:0]    y_other,
    input  logic                  ink,
    output logic                  empty,
    input  logic                  pop,
    output logic                  ink_read,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_W_BITS-1:0] cfg_data
);

    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_W_BITS-1:0] width_reg;
    logic [CFG_H_BITS-1:0] height_reg;
    logic [EW-1:0]         eff_w;
    logic [HW-1:0]         eff_h;
    logic                  clearing, cmd_valid, cmd_pop;
    cmd_t                  cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W_BITS'(256);
            height_reg <= CFG_H_BITS'(128);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data[CFG_H_BITS-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // clamp the visible area to the store geometry
    assign eff_w = (32'(width_reg) > MAX_WIDTH) ? EW'(MAX_WIDTH) : EW'(width_reg);
    assign eff_h = (32'(height_reg) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_reg);

    mfde_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .EW(EW), .HW(HW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_other   (x_other),
        .y_other   (y_other),
        .ink       (ink),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    mfde_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .EW(EW), .HW(HW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .ink_read  (ink_read)
    );

endmodule
